FILE: rtl/core/dbhc_pkg.sv
package dbhc_pkg;

    // field widths of the request, response and configuration channels
    localparam int REQ_W      = 3;
    localparam int SLOT_NUM_W = 4;
    localparam int STATUS_W   = 2;
    localparam int OFFSET_W   = 25;
    localparam int SEQ_W      = 64;
    localparam int RUN_W      = 2;
    localparam int SLOT_ST_W  = 2;
    localparam int PAYLOAD_W  = 21;
    localparam int STRIDE_W   = 22;

    typedef logic [REQ_W-1:0]      t_req;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [RUN_W-1:0]      t_run;
    typedef logic [SLOT_ST_W-1:0]  t_slot_st;
    typedef logic [PAYLOAD_W-1:0]  t_payload;
    typedef logic [SLOT_NUM_W-1:0] t_slot_num;
    typedef logic [OFFSET_W-1:0]   t_offset;
    typedef logic [SEQ_W-1:0]      t_seq;

    // request codes
    localparam t_req REQ_ACQ_WR  = 3'd0;
    localparam t_req REQ_PUBLISH = 3'd1;
    localparam t_req REQ_ACQ_RD  = 3'd2;
    localparam t_req REQ_RELEASE = 3'd3;
    localparam t_req REQ_SHUTDN  = 3'd4;
    localparam t_req REQ_CRASH   = 3'd5;
    localparam t_req REQ_QUERY   = 3'd6;

    // response status codes
    localparam t_status STATUS_GRANTED = 2'd0;
    localparam t_status STATUS_WAIT    = 2'd1;
    localparam t_status STATUS_REFUSED = 2'd2;
    localparam t_status STATUS_STOPPED = 2'd3;

    // run states
    localparam t_run RUN_RUNNING  = 2'd0;
    localparam t_run RUN_SHUTDOWN = 2'd1;
    localparam t_run RUN_CRASHED  = 2'd2;

    // slot states
    localparam t_slot_st SLOT_FREE    = 2'd0;
    localparam t_slot_st SLOT_WRITING = 2'd1;
    localparam t_slot_st SLOT_READY   = 2'd2;
    localparam t_slot_st SLOT_READING = 2'd3;

    // payload size after reset
    localparam t_payload PAYLOAD_RST = 21'd16;

endpackage

FILE: rtl/core/dbhc_if.sv
// request channel
interface dbhc_req_if;
    import dbhc_pkg::*;

    logic      valid;
    logic      ready;
    t_req      req_type;
    t_slot_num query_slot;

    modport source (output valid, output req_type, output query_slot, input ready);
    modport sink   (input valid, input req_type, input query_slot, output ready);
endinterface

// response channel
interface dbhc_resp_if;
    import dbhc_pkg::*;

    logic      valid;
    logic      ready;
    t_status   status;
    t_slot_num granted_slot;
    t_offset   payload_offset;
    t_seq      frame_sequence;
    t_run      run_state;
    t_slot_st  slot_state;

    modport source (
        output valid, output status, output granted_slot, output payload_offset,
        output frame_sequence, output run_state, output slot_state, input ready
    );
    modport sink (
        input valid, input status, input granted_slot, input payload_offset,
        input frame_sequence, input run_state, input slot_state, output ready
    );
endinterface

// configuration write channel
interface dbhc_cfg_if;
    import dbhc_pkg::*;

    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/double_buffer_handshake_controller_top.sv
// Slot coordinator for one producer and one consumer sharing SLOT_COUNT payload slots.
// Channels: i_req carries a request code and a query slot, o_resp returns exactly one
// response per request (status, granted slot, payload byte offset, frame sequence,
// run state, queried slot state), i_cfg writes the payload size per slot in bytes.
// A request passes through two registers, the input register and the response register.
// Throughput is one request per cycle while o_resp is not stalled and no stride rebuild
// is under way; the slot decision is a single pass over the slot state registers.
// The slot stride (payload size rounded up to ALIGN_BYTES) is rebuilt by a two-stage
// reciprocal multiply after each configuration write; i_req.ready is low while the
// write moves through both stages. i_cfg.ready is always high.
// Reset (i_rst_n low, synchronous): all slots free, no side holds a slot, sequence
// counter zero, block running, payload size 16, both channels empty.
// When the receiver stalls o_resp, the response is held, one more request is taken
// into the input register, and then i_req.ready falls until the response is taken.
module double_buffer_handshake_controller_top #(
    parameter int SLOT_COUNT  = 2,
    parameter int ALIGN_BYTES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dbhc_req_if.sink           i_req,
    dbhc_resp_if.source        o_resp,
    dbhc_cfg_if.sink           i_cfg
);
    import dbhc_pkg::*;

    localparam int SW       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NUM_W    = STRIDE_W;
    localparam int KSH      = NUM_W;
    localparam int RECIP_W  = NUM_W + 1;
    localparam int QPROD_W  = NUM_W + RECIP_W;
    localparam int ALIGN_W  = 13;
    localparam int SPROD_W  = NUM_W + ALIGN_W;
    localparam int PROD_W   = OFFSET_W + 1;
    localparam longint RECIP      = (64'd1 << KSH) / ALIGN_BYTES;
    localparam longint Q_RST      = (16 + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam longint STRIDE_RST = Q_RST * ALIGN_BYTES;

    typedef logic [SW-1:0] t_idx;

    // configuration and stride registers
    t_payload             r_payload_bytes;
    logic [NUM_W-1:0]     r_q_est;
    logic [STRIDE_W-1:0]  r_stride;
    logic [1:0]           r_cfg_pipe;

    // pipeline registers
    logic                 r_in_valid;
    t_req                 r_in_req;
    t_slot_num            r_in_query;
    logic                 r_out_valid;
    t_status              r_out_status;
    t_slot_num            r_out_gslot;
    t_offset              r_out_offset;
    t_seq                 r_out_seq;
    t_run                 r_out_run;
    t_slot_st             r_out_sstate;

    // slot and ownership state
    t_slot_st             r_slot_st [SLOT_COUNT];
    logic                 r_wr_holds;
    t_idx                 r_wr_slot;
    logic                 r_rd_holds;
    t_idx                 r_rd_slot;
    t_seq                 r_last_seq;
    t_run                 r_run;

    // next-state values
    t_slot_st             n_slot_st [SLOT_COUNT];
    logic                 n_wr_holds;
    t_idx                 n_wr_slot;
    logic                 n_rd_holds;
    t_idx                 n_rd_slot;
    t_seq                 n_last_seq;
    t_run                 n_run;
    t_status              n_status;
    t_slot_num            n_gslot;
    t_offset              n_offset;
    t_seq                 n_seq;
    t_slot_st             n_sstate;

    logic                 w_cfg_fire;
    logic                 w_out_free;
    logic                 w_fire;
    logic [NUM_W-1:0]     w_num;
    logic [QPROD_W-1:0]   w_qprod;
    logic [SPROD_W-1:0]   w_sprod;
    logic [NUM_W-1:0]     w_rem;
    logic [SLOT_COUNT-1:0] w_free_vec;
    logic [SLOT_COUNT-1:0] w_ready_vec;
    logic [SLOT_COUNT-1:0] w_writing_vec;
    t_idx                 w_free_idx;
    t_idx                 w_ready_idx;
    t_idx                 w_grant_idx;
    logic [PROD_W-1:0]    w_prod;
    logic                 w_query_ok;

    // handshakes
    assign w_cfg_fire   = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready  = 1'b1;
    assign w_out_free   = !r_out_valid || o_resp.ready;
    assign w_fire       = r_in_valid && w_out_free;
    assign i_req.ready  = (!r_in_valid || w_out_free) && (r_cfg_pipe == 2'b00);

    // stride: quotient estimate by reciprocal, then one correction step
    assign w_num   = NUM_W'(r_payload_bytes) + NUM_W'(ALIGN_BYTES - 1);
    assign w_qprod = QPROD_W'(w_num) * QPROD_W'(RECIP);
    assign w_sprod = SPROD_W'(r_q_est) * SPROD_W'(ALIGN_BYTES);
    assign w_rem   = w_num - w_sprod[NUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_bytes <= PAYLOAD_RST;
            r_q_est         <= NUM_W'(Q_RST);
            r_stride        <= STRIDE_W'(STRIDE_RST);
            r_cfg_pipe      <= 2'b00;
        end else begin
            if (w_cfg_fire) begin
                r_payload_bytes <= i_cfg.data;
            end
            r_cfg_pipe <= {r_cfg_pipe[0], w_cfg_fire};
            r_q_est    <= w_qprod[KSH +: NUM_W];
            if (w_rem >= NUM_W'(ALIGN_BYTES)) begin
                r_stride <= w_sprod[STRIDE_W-1:0] + STRIDE_W'(ALIGN_BYTES);
            end else begin
                r_stride <= w_sprod[STRIDE_W-1:0];
            end
        end
    end

    // per-slot flags and lowest free slot; at most one slot is ready at a time
    always_comb begin
        w_free_idx  = '0;
        w_ready_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            w_free_vec[i]    = (r_slot_st[i] == SLOT_FREE);
            w_ready_vec[i]   = (r_slot_st[i] == SLOT_READY);
            w_writing_vec[i] = (r_slot_st[i] == SLOT_WRITING);
            if (w_free_vec[i]) begin
                w_free_idx = SW'(i);
            end
            if (w_ready_vec[i]) begin
                w_ready_idx = SW'(i);
            end
        end
    end

    // payload offset of the slot an acquire hands out
    assign w_grant_idx = (r_in_req == REQ_ACQ_WR) ? w_free_idx : w_ready_idx;
    assign w_prod      = PROD_W'(w_grant_idx) * PROD_W'(r_stride);
    assign w_query_ok  = ({1'b0, r_in_query} < (SLOT_NUM_W + 1)'(SLOT_COUNT));

    // request decode and state update; the ready slot always carries the last
    // published sequence, since no new publish can happen until it is taken
    always_comb begin
        n_slot_st  = r_slot_st;
        n_wr_holds = r_wr_holds;
        n_wr_slot  = r_wr_slot;
        n_rd_holds = r_rd_holds;
        n_rd_slot  = r_rd_slot;
        n_last_seq = r_last_seq;
        n_run      = r_run;
        n_status   = STATUS_GRANTED;
        n_gslot    = '0;
        n_offset   = '0;
        n_seq      = '0;
        n_sstate   = SLOT_FREE;
        unique case (r_in_req)
            REQ_ACQ_WR: begin
                if (r_wr_holds) begin
                    n_status = STATUS_REFUSED;
                end else if (r_run != RUN_RUNNING) begin
                    n_status = STATUS_STOPPED;
                end else if (!(|w_free_vec) || (|w_ready_vec)) begin
                    n_status = STATUS_WAIT;
                end else begin
                    n_slot_st[w_free_idx] = SLOT_WRITING;
                    n_wr_holds = 1'b1;
                    n_wr_slot  = w_free_idx;
                    n_gslot    = SLOT_NUM_W'(w_free_idx);
                    n_offset   = w_prod[OFFSET_W-1:0];
                end
            end
            REQ_PUBLISH: begin
                if (!r_wr_holds) begin
                    n_status = STATUS_REFUSED;
                end else if (r_run != RUN_RUNNING) begin
                    n_slot_st[r_wr_slot] = SLOT_FREE;
                    n_wr_holds = 1'b0;
                    n_status   = STATUS_STOPPED;
                end else begin
                    n_last_seq = r_last_seq + t_seq'(1);
                    n_slot_st[r_wr_slot] = SLOT_READY;
                    n_wr_holds = 1'b0;
                end
            end
            REQ_ACQ_RD: begin
                if (r_rd_holds) begin
                    n_status = STATUS_REFUSED;
                end else if (r_run != RUN_RUNNING) begin
                    n_status = STATUS_STOPPED;
                end else if (!(|w_ready_vec)) begin
                    n_status = STATUS_WAIT;
                end else begin
                    n_slot_st[w_ready_idx] = SLOT_READING;
                    n_rd_holds = 1'b1;
                    n_rd_slot  = w_ready_idx;
                    n_gslot    = SLOT_NUM_W'(w_ready_idx);
                    n_offset   = w_prod[OFFSET_W-1:0];
                    n_seq      = r_last_seq;
                end
            end
            REQ_RELEASE: begin
                if (!r_rd_holds) begin
                    n_status = STATUS_REFUSED;
                end else begin
                    n_slot_st[r_rd_slot] = SLOT_FREE;
                    n_rd_holds = 1'b0;
                end
            end
            REQ_SHUTDN: begin
                if (r_run == RUN_RUNNING) begin
                    n_run = RUN_SHUTDOWN;
                end
            end
            REQ_CRASH: begin
                n_run = RUN_CRASHED;
            end
            REQ_QUERY: begin
                if (w_query_ok) begin
                    n_sstate = r_slot_st[r_in_query[SW-1:0]];
                end
            end
            default: begin
            end
        endcase
    end

    // input register, state and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_st[i] <= SLOT_FREE;
            end
            r_wr_holds <= 1'b0;
            r_wr_slot  <= '0;
            r_rd_holds <= 1'b0;
            r_rd_slot  <= '0;
            r_last_seq <= '0;
            r_run      <= RUN_RUNNING;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
                r_in_req   <= i_req.req_type;
                r_in_query <= i_req.query_slot;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_slot_st    <= n_slot_st;
                r_wr_holds   <= n_wr_holds;
                r_wr_slot    <= n_wr_slot;
                r_rd_holds   <= n_rd_holds;
                r_rd_slot    <= n_rd_slot;
                r_last_seq   <= n_last_seq;
                r_run        <= n_run;
                r_out_valid  <= 1'b1;
                r_out_status <= n_status;
                r_out_gslot  <= n_gslot;
                r_out_offset <= n_offset;
                r_out_seq    <= n_seq;
                r_out_run    <= n_run;
                r_out_sstate <= n_sstate;
            end else if (o_resp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response outputs
    assign o_resp.valid          = r_out_valid;
    assign o_resp.status         = r_out_status;
    assign o_resp.granted_slot   = r_out_gslot;
    assign o_resp.payload_offset = r_out_offset;
    assign o_resp.frame_sequence = r_out_seq;
    assign o_resp.run_state      = r_out_run;
    assign o_resp.slot_state     = r_out_sstate;

    // never more than one published frame waiting
    a_one_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_ready_vec))
        else $error("more than one slot ready");

    // a writing slot exists exactly while the producer holds one
    a_writer_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_writing_vec) == 32'(r_wr_holds))
        else $error("writing slots disagree with producer hold flag");

    // the producer's held slot is in the writing state
    a_writer_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_holds |-> (r_slot_st[r_wr_slot] == SLOT_WRITING))
        else $error("producer holds a slot that is not writing");

    // requests are held off while the stride is rebuilt
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> !i_req.ready)
        else $error("request accepted during stride update");

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import dbhc_pkg::*;

    localparam int          SLOTS       = 2;
    localparam logic [63:0] ALIGN       = 64'd16;
    localparam t_req        REQ_UNKNOWN = 3'd7;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          TAIL_CYCLES = 8;
    localparam int          PHASE_ITEMS = 200;
    localparam int          PRINT_LIMIT = 200;

    // one response transaction, field by field
    typedef struct packed {
        t_status   status;
        t_slot_num slot;
        t_offset   byte_off;
        t_seq      seq;
        t_run      run;
        t_slot_st  slot_st;
    } t_resp;

    logic clk = 1'b0;
    logic rst_n;

    dbhc_req_if  req_ch ();
    dbhc_resp_if rsp_ch ();
    dbhc_cfg_if  cfg_ch ();

    double_buffer_handshake_controller_top #(
        .SLOT_COUNT  (SLOTS),
        .ALIGN_BYTES (int'(ALIGN))
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_resp  (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // slot bookkeeping mirrored from accepted requests
    t_slot_st ctl_slot_st [SLOTS] = '{default: SLOT_FREE};
    t_seq     ctl_slot_seq [SLOTS] = '{default: '0};
    bit       ctl_wr_holds = 1'b0;
    int       ctl_wr_slot  = 0;
    bit       ctl_rd_holds = 1'b0;
    int       ctl_rd_slot  = 0;
    t_seq     ctl_last_seq = '0;
    t_run     ctl_run      = RUN_RUNNING;
    t_payload ctl_payload  = PAYLOAD_RST;

    t_resp pending_resps [$];
    int    fail_count   = 0;
    int    tx_idle_pct  = 0;
    int    rx_stall_pct = 0;

    // clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic t_offset slot_offset(int s);
        logic [63:0] stride;
        stride = ((64'(ctl_payload) + ALIGN - 64'd1) / ALIGN) * ALIGN;
        return t_offset'(64'(s) * stride);
    endfunction

    // ready slot with the lowest sequence, lowest index on a tie
    function automatic int ready_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (ctl_slot_st[i] == SLOT_READY &&
                (best < 0 || ctl_slot_seq[i] < ctl_slot_seq[best])) best = i;
        return best;
    endfunction

    // apply one request to the slot bookkeeping and return its response
    function automatic t_resp next_response(t_req r, t_slot_num q);
        t_resp e;
        int    fs;
        int    rs;
        e  = '0;
        fs = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (ctl_slot_st[i] == SLOT_FREE) fs = i;
        rs = ready_slot();
        case (r)
            REQ_ACQ_WR: begin
                if (ctl_wr_holds) e.status = STATUS_REFUSED;
                else if (ctl_run != RUN_RUNNING) e.status = STATUS_STOPPED;
                else if (fs < 0 || rs >= 0) e.status = STATUS_WAIT;
                else begin
                    ctl_slot_st[fs] = SLOT_WRITING;
                    ctl_wr_holds    = 1'b1;
                    ctl_wr_slot     = fs;
                    e.slot          = t_slot_num'(fs);
                    e.byte_off      = slot_offset(fs);
                end
            end
            REQ_PUBLISH: begin
                if (!ctl_wr_holds) e.status = STATUS_REFUSED;
                else if (ctl_run != RUN_RUNNING) begin
                    // stopped: the held slot goes back to free
                    ctl_slot_st[ctl_wr_slot] = SLOT_FREE;
                    ctl_wr_holds             = 1'b0;
                    e.status                 = STATUS_STOPPED;
                end else begin
                    ctl_last_seq              = ctl_last_seq + 64'd1;
                    ctl_slot_seq[ctl_wr_slot] = ctl_last_seq;
                    ctl_slot_st[ctl_wr_slot]  = SLOT_READY;
                    ctl_wr_holds              = 1'b0;
                end
            end
            REQ_ACQ_RD: begin
                if (ctl_rd_holds) e.status = STATUS_REFUSED;
                else if (ctl_run != RUN_RUNNING) e.status = STATUS_STOPPED;
                else if (rs < 0) e.status = STATUS_WAIT;
                else begin
                    ctl_slot_st[rs] = SLOT_READING;
                    ctl_rd_holds    = 1'b1;
                    ctl_rd_slot     = rs;
                    e.slot          = t_slot_num'(rs);
                    e.byte_off      = slot_offset(rs);
                    e.seq           = ctl_slot_seq[rs];
                end
            end
            REQ_RELEASE: begin
                if (!ctl_rd_holds) e.status = STATUS_REFUSED;
                else begin
                    ctl_slot_st[ctl_rd_slot]  = SLOT_FREE;
                    ctl_slot_seq[ctl_rd_slot] = '0;
                    ctl_rd_holds              = 1'b0;
                end
            end
            REQ_SHUTDN: begin
                if (ctl_run == RUN_RUNNING) ctl_run = RUN_SHUTDOWN;
            end
            REQ_CRASH: begin
                ctl_run = RUN_CRASHED;
            end
            REQ_QUERY: begin
                if (q < SLOTS) e.slot_st = ctl_slot_st[q];
            end
            default: ;
        endcase
        e.run = ctl_run;
        return e;
    endfunction

    // send one request transaction, with random idle cycles ahead of it
    task automatic send_request(t_req r, t_slot_num q);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r;
        req_ch.query_slot <= q;
        do @(posedge clk); while (!req_ch.ready);
        pending_resps.push_back(next_response(r, q));
    endtask

    // stop sending and wait until every response is back
    task automatic settle_responses();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_resps.size() != 0);
    endtask

    // payload size write, only with the block idle
    task automatic write_payload(t_payload v);
        settle_responses();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        ctl_payload  = v;
    endtask

    // producer and consumer traffic that mostly follows the protocol
    task automatic send_mixed(int n);
        int   roll;
        t_req r;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 40) r = ctl_wr_holds ? REQ_PUBLISH : REQ_ACQ_WR;
            else if (roll < 80) r = ctl_rd_holds ? REQ_RELEASE : REQ_ACQ_RD;
            else if (roll < 88) r = REQ_QUERY;
            else begin
                do r = t_req'($urandom_range(7));
                while (r == REQ_SHUTDN || r == REQ_CRASH);
            end
            send_request(r, t_slot_num'($urandom_range(15)));
            if ($urandom_range(199) == 0) settle_responses();
        end
    endtask

    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_request(REQ_QUERY, 4'd0);
        send_request(REQ_QUERY, 4'd15);
        send_request(REQ_ACQ_RD, 4'd0);
        send_request(REQ_PUBLISH, 4'd0);
        send_request(REQ_RELEASE, 4'd0);
        send_request(REQ_ACQ_WR, 4'd0);
        send_request(REQ_ACQ_WR, 4'd0);
        send_request(REQ_PUBLISH, 4'd0);
        send_request(REQ_ACQ_WR, 4'd0);
        send_request(REQ_QUERY, 4'd0);
        send_request(REQ_ACQ_RD, 4'd0);
        send_request(REQ_ACQ_RD, 4'd0);
        send_request(REQ_ACQ_WR, 4'd0);
        send_request(REQ_QUERY, 4'd1);
        send_request(REQ_PUBLISH, 4'd0);
        send_request(REQ_RELEASE, 4'd0);
        send_request(REQ_ACQ_WR, 4'd0);
        send_request(REQ_ACQ_RD, 4'd0);
        send_request(REQ_ACQ_WR, 4'd0);
        send_request(REQ_UNKNOWN, 4'd5);
        send_request(REQ_QUERY, 4'd8);
    endtask

    // offsets of both slots under several payload sizes
    task automatic test_config();
        t_payload sizes [7];
        sizes = '{21'd0, 21'd1, 21'd16, 21'd17, 21'h1FFFFF, 21'd1048576, 21'd0};
        sizes[6] = t_payload'($urandom_range(2, 4095));
        // bring every slot back to free
        send_request(REQ_PUBLISH, 4'd0);
        send_request(REQ_RELEASE, 4'd0);
        send_request(REQ_ACQ_RD, 4'd0);
        send_request(REQ_RELEASE, 4'd0);
        foreach (sizes[i]) begin
            write_payload(sizes[i]);
            send_request(REQ_ACQ_WR, 4'd0);
            send_request(REQ_PUBLISH, 4'd0);
            send_request(REQ_ACQ_RD, 4'd0);
            send_request(REQ_ACQ_WR, 4'd0);
            send_request(REQ_PUBLISH, 4'd0);
            send_request(REQ_RELEASE, 4'd0);
            send_request(REQ_ACQ_RD, 4'd0);
            send_request(REQ_RELEASE, 4'd0);
        end
    endtask

    task automatic test_random_phases();
        int idle_set  [4];
        int stall_set [4];
        idle_set  = '{0, 70, 0, 27};
        stall_set = '{0, 0, 70, 27};
        foreach (idle_set[p]) begin
            if ($urandom_range(1) == 0) write_payload(t_payload'($urandom_range(1, 256)));
            else write_payload(t_payload'($urandom_range(0, 21'h1FFFFF)));
            tx_idle_pct  = idle_set[p];
            rx_stall_pct = stall_set[p];
            send_mixed(PHASE_ITEMS);
        end
    endtask

    // shutdown and crash are terminal, so they come last
    task automatic test_stop();
        tx_idle_pct  = 27;
        rx_stall_pct = 27;
        if (ctl_wr_holds) send_request(REQ_PUBLISH, 4'd0);
        if (ctl_rd_holds) send_request(REQ_RELEASE, 4'd0);
        if (ready_slot() >= 0) begin
            send_request(REQ_ACQ_RD, 4'd0);
            send_request(REQ_RELEASE, 4'd0);
        end
        send_request(REQ_ACQ_WR, 4'd0);
        send_request(REQ_PUBLISH, 4'd0);
        send_request(REQ_ACQ_RD, 4'd0);
        send_request(REQ_ACQ_WR, 4'd0);
        send_request(REQ_SHUTDN, 4'd0);
        send_request(REQ_ACQ_WR, 4'd0);
        send_request(REQ_PUBLISH, 4'd0);
        send_request(REQ_ACQ_WR, 4'd0);
        send_request(REQ_ACQ_RD, 4'd0);
        send_request(REQ_RELEASE, 4'd0);
        send_request(REQ_ACQ_RD, 4'd0);
        send_request(REQ_SHUTDN, 4'd0);
        send_request(REQ_QUERY, 4'd1);
        send_request(REQ_CRASH, 4'd0);
        send_request(REQ_SHUTDN, 4'd0);
        send_request(REQ_CRASH, 4'd0);
        send_request(REQ_QUERY, 4'd0);
        for (int k = 0; k < 60; k++)
            send_request(t_req'($urandom_range(7)), t_slot_num'($urandom_range(15)));
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT)
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    // response receiver: random stalls, compare each transaction in order
    initial begin
        t_resp want;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (pending_resps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= PRINT_LIMIT) $error("response with no request pending");
                end else begin
                    want = pending_resps.pop_front();
                    check_field("status", want.status, rsp_ch.status);
                    check_field("granted_slot", want.slot, rsp_ch.granted_slot);
                    check_field("payload_offset", want.byte_off, rsp_ch.payload_offset);
                    check_field("frame_sequence", want.seq, rsp_ch.frame_sequence);
                    check_field("run_state", want.run, rsp_ch.run_state);
                    check_field("slot_state", want.slot_st, rsp_ch.slot_state);
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // test sequence
    initial begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_QUERY;
        req_ch.query_slot <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= PAYLOAD_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config();
        test_random_phases();
        test_stop();
        settle_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
